/* rtl/core/gdbt_pkg.sv */
// Package for the geo distance band toggle block: widths, constants and the
// side-band type that the top level carries beside the cosine pipeline.
// No dependencies.
package gdbt_pkg;

    // Number of statistic slots that can ever match.
    localparam int NUM_SLOTS = 4;
    localparam int NUM_REGS  = 4;

    // Taylor terms of the cosine after the constant term.
    localparam int NUM_TERMS = 7;

    // Cosine pipeline latency: fold, split multiply, radians, square,
    // three stages per term, final subtract.
    localparam int COS_LAT = 4 + 3 * NUM_TERMS + 1;

    // Latency from an accepted item to its result strobe.
    localparam int ITEM_LAT = COS_LAT + 4;

    // Mean-latitude fold, in units of 2^-21 degree.
    localparam logic [28:0] FOLD_LIMIT = 29'd188743680;
    localparam logic [28:0] HALF_TURN  = 29'd377487360;

    // Degrees to radians, round(pi/180 * 2^41), split into two 18-bit halves.
    localparam logic [35:0] RADQ    = 36'd38380196136;
    localparam logic [17:0] RAD_HI  = RADQ[35:18];
    localparam logic [17:0] RAD_LO  = RADQ[17:0];

    // One in Q30.
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // Divisors of the Taylor terms, (2k-1)*2k for k = 1..7.
    localparam logic [7:0] TERM_DIV [1:NUM_TERMS] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
    };

    // Squared band thresholds in units of 2^-40 degree^2.
    localparam logic [62:0] TH1 = 63'd3598705;
    localparam logic [62:0] TH2 = 63'd230317107;
    localparam logic [62:0] TH3 = 63'd93282027007;

    // Band codes.
    localparam logic [2:0] BAND_1 = 3'd1;
    localparam logic [2:0] BAND_2 = 3'd2;
    localparam logic [2:0] BAND_3 = 3'd3;
    localparam logic [2:0] BAND_4 = 3'd4;

    // Slot changes in 2-bit two's complement.
    localparam logic [1:0] DELTA_NONE = 2'b00;
    localparam logic [1:0] DELTA_INC  = 2'b01;
    localparam logic [1:0] DELTA_DEC  = 2'b11;

    // Per-item data that travels beside the cosine pipeline.
    typedef struct packed {
        logic [29:0] dlon;
        logic [28:0] uy;
        logic        present;
    } side_t;

endpackage

/* rtl/core/gdbt_cos.sv */
// Pipelined Q30 cosine magnitude of the mean latitude (Taylor series to x^14).
// Depends on gdbt_pkg. Fully pipelined, one item per cycle.
module gdbt_cos (
    input  logic        clk,
    input  logic [28:0] lat_sum_mag,
    output logic [30:0] cos_mag
);
    import gdbt_pkg::*;

    logic [27:0] af_reg;
    logic [27:0] af_next;
    logic [45:0] ph_reg;
    logic [45:0] pl_reg;
    logic [30:0] x_reg;
    logic [63:0] x_sum;
    logic [61:0] x_sq;

    // Term pipeline: index 0 holds the constant term.
    logic [31:0] x2_c   [0:NUM_TERMS];
    logic [30:0] term_c [0:NUM_TERMS];
    logic [32:0] even_c [0:NUM_TERMS];
    logic [32:0] odd_c  [0:NUM_TERMS];

    logic [31:0] p_a    [1:NUM_TERMS];
    logic [31:0] x2_a   [1:NUM_TERMS];
    logic [32:0] even_a [1:NUM_TERMS];
    logic [32:0] odd_a  [1:NUM_TERMS];

    logic [31:0] qe_b   [1:NUM_TERMS];
    logic [31:0] p_b    [1:NUM_TERMS];
    logic [31:0] x2_b   [1:NUM_TERMS];
    logic [32:0] even_b [1:NUM_TERMS];
    logic [32:0] odd_b  [1:NUM_TERMS];

    logic [30:0] c_reg;
    logic [30:0] c_next;

    // Fold the latitude sum into the first quadrant.
    always_comb
    begin
        if (lat_sum_mag > FOLD_LIMIT)
        begin
            af_next = 28'(HALF_TURN - lat_sum_mag);
        end
        else
        begin
            af_next = lat_sum_mag[27:0];
        end
    end

    assign x_sum = {ph_reg, 18'd0} + {18'd0, pl_reg};
    assign x_sq  = x_reg * x_reg;

    // Front stages: fold, split radian multiply, radians, square.
    always_ff @(posedge clk)
    begin
        af_reg    <= af_next;
        ph_reg    <= af_reg * RAD_HI;
        pl_reg    <= af_reg * RAD_LO;
        x_reg     <= x_sum[62:32];
        x2_c[0]   <= x_sq[61:30];
        term_c[0] <= Q30_ONE;
        even_c[0] <= 33'(Q30_ONE);
        odd_c[0]  <= '0;
    end

    // Each term: product with x^2, reciprocal estimate, exact correction.
    for (genvar k = 1; k <= NUM_TERMS; k++)
    begin : g_term
        localparam int unsigned     D  = int'(TERM_DIV[k]);
        localparam longint unsigned MR = (64'd1 << 32) / D;

        logic [62:0] prod;
        logic [63:0] qprod;
        logic [39:0] chk;
        logic [39:0] rem;
        logic [31:0] q_fix;

        assign prod  = term_c[k-1] * x2_c[k-1];
        assign qprod = p_a[k] * 32'(MR);
        assign chk   = {8'd0, qe_b[k]} * 40'(D);
        assign rem   = {8'd0, p_b[k]} - chk;
        assign q_fix = qe_b[k] + ((rem >= 40'(D)) ? 32'd1 : 32'd0);

        always_ff @(posedge clk)
        begin
            p_a[k]    <= prod[61:30];
            x2_a[k]   <= x2_c[k-1];
            even_a[k] <= even_c[k-1];
            odd_a[k]  <= odd_c[k-1];

            qe_b[k]   <= qprod[63:32];
            p_b[k]    <= p_a[k];
            x2_b[k]   <= x2_a[k];
            even_b[k] <= even_a[k];
            odd_b[k]  <= odd_a[k];

            x2_c[k]   <= x2_b[k];
            term_c[k] <= q_fix[30:0];
        end

        // Odd terms are subtracted, even terms added.
        if ((k % 2) == 1)
        begin : g_odd
            always_ff @(posedge clk)
            begin
                odd_c[k]  <= odd_b[k] + 33'(q_fix[30:0]);
                even_c[k] <= even_b[k];
            end
        end
        else
        begin : g_even
            always_ff @(posedge clk)
            begin
                even_c[k] <= even_b[k] + 33'(q_fix[30:0]);
                odd_c[k]  <= odd_b[k];
            end
        end
    end

    // Final difference, clamped at zero.
    always_comb
    begin
        if (even_c[NUM_TERMS] > odd_c[NUM_TERMS])
        begin
            c_next = 31'(even_c[NUM_TERMS] - odd_c[NUM_TERMS]);
        end
        else
        begin
            c_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign cos_mag = c_reg;

endmodule

/* rtl/core/geo_distance_band_toggle.sv */
// Top level of the geo distance band toggle block: input stage, side-band
// delay, distance squares, band compare and slot registers.
// Depends on gdbt_pkg and gdbt_cos.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | start, busy          | tail/head latitude/longitude, edge_present
//  config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//  result   | done                 | band, delta0..delta3
//
// One item is accepted per cycle; its result strobes on done after the input
// stage, the cosine pipeline, the scaled offset, the squares and the band compare.
// busy is always low and cfg_ready always high.
// Reset clears the valid bits and sets the slot bands to 1, 2, 3 and 4.
// The receiver cannot stall, so the pipeline advances every cycle.
module geo_distance_band_toggle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [27:0] tail_latitude,
    input  logic signed [28:0] tail_longitude,
    input  logic signed [27:0] head_latitude,
    input  logic signed [28:0] head_longitude,
    input  logic               edge_present,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    output logic               done,
    output logic [2:0]         band,
    output logic signed [1:0]  delta0,
    output logic signed [1:0]  delta1,
    output logic signed [1:0]  delta2,
    output logic signed [1:0]  delta3
);
    import gdbt_pkg::*;

    logic signed [28:0] lat_sum;
    logic signed [29:0] lon_diff;
    logic signed [28:0] lat_diff;
    logic               accept;

    logic               v0_reg;
    logic [28:0]        sum_mag_reg;
    side_t              side0_reg;
    side_t              side0_next;

    logic [COS_LAT-1:0] vld_reg;
    side_t              side_reg [0:COS_LAT-1];
    logic [30:0]        cos_mag;

    logic               vu_reg;
    logic [30:0]        ux_reg;
    logic [28:0]        uy_u_reg;
    logic               pres_u_reg;
    logic [60:0]        ux_prod;

    logic               vq_reg;
    logic [61:0]        ux2_reg;
    logic [57:0]        uy2_reg;
    logic               pres_q_reg;

    logic [62:0]        d2;
    logic [2:0]         band_next;
    logic [2:0]         slot_band_reg [0:NUM_REGS-1];
    logic [1:0]         delta_next [0:NUM_REGS-1];
    logic [1:0]         delta_reg  [0:NUM_REGS-1];
    logic               done_reg;
    logic [2:0]         band_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Input stage: latitude sum, offsets and their magnitudes.
    assign lat_sum  = 29'(tail_latitude) + 29'(head_latitude);
    assign lon_diff = 30'(head_longitude) - 30'(tail_longitude);
    assign lat_diff = 29'(head_latitude) - 29'(tail_latitude);

    always_comb
    begin
        side0_next.dlon    = lon_diff[29] ? 30'(-lon_diff) : 30'(lon_diff);
        side0_next.uy      = lat_diff[28] ? 29'(-lat_diff) : 29'(lat_diff);
        side0_next.present = edge_present;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_mag_reg <= lat_sum[28] ? 29'(-lat_sum) : 29'(lat_sum);
        side0_reg   <= side0_next;
    end

    gdbt_cos u_cos (
        .clk         (clk),
        .lat_sum_mag (sum_mag_reg),
        .cos_mag     (cos_mag)
    );

    // Side band delayed to meet the cosine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[COS_LAT-2:0], v0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side0_reg;
        for (int i = 1; i < COS_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // East-west offset scaled by the cosine.
    assign ux_prod = side_reg[COS_LAT-1].dlon * cos_mag;

    // Squares of both offsets, then the band compare.
    assign d2 = 63'(ux2_reg) + 63'(uy2_reg);

    always_comb
    begin
        priority if (d2 < TH1)
        begin
            band_next = BAND_1;
        end
        else if (d2 < TH2)
        begin
            band_next = BAND_2;
        end
        else if (d2 < TH3)
        begin
            band_next = BAND_3;
        end
        else
        begin
            band_next = BAND_4;
        end
    end

    // Slot changes; slots beyond NUM_SLOTS never match.
    always_comb
    begin
        for (int j = 0; j < NUM_REGS; j++)
        begin
            if (vq_reg && (j < NUM_SLOTS) && (slot_band_reg[j] == band_next))
            begin
                delta_next[j] = pres_q_reg ? DELTA_DEC : DELTA_INC;
            end
            else
            begin
                delta_next[j] = DELTA_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vu_reg   <= 1'b0;
            vq_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int j = 0; j < NUM_REGS; j++)
            begin
                delta_reg[j] <= DELTA_NONE;
            end
        end
        else
        begin
            vu_reg   <= vld_reg[COS_LAT-1];
            vq_reg   <= vu_reg;
            done_reg <= vq_reg;
            for (int j = 0; j < NUM_REGS; j++)
            begin
                delta_reg[j] <= delta_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg     <= ux_prod[60:30];
        uy_u_reg   <= side_reg[COS_LAT-1].uy;
        pres_u_reg <= side_reg[COS_LAT-1].present;
        ux2_reg    <= ux_reg * ux_reg;
        uy2_reg    <= uy_u_reg * uy_u_reg;
        pres_q_reg <= pres_u_reg;
        band_reg   <= band_next;
    end

    // Slot band registers; writes beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_REGS; j++)
            begin
                slot_band_reg[j] <= 3'(j + 1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int j = 0; j < NUM_REGS; j++)
            begin
                if (cfg_index == 3'(j))
                begin
                    slot_band_reg[j] <= cfg_data;
                end
            end
        end
    end

    assign done   = done_reg;
    assign band   = band_reg;
    assign delta0 = delta_reg[0];
    assign delta1 = delta_reg[1];
    assign delta2 = delta_reg[2];
    assign delta3 = delta_reg[3];

    // Every accepted item yields a result strobe on done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##ITEM_LAT done)
        else $error("accepted item produced no result");

    // No result appears without a matching accepted item.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, ITEM_LAT))
        else $error("result without accepted item");

    // A result always carries a legal band.
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (band == BAND_1 || band == BAND_2 || band == BAND_3 || band == BAND_4))
        else $error("band out of range");

    // Slot changes are zero between results.
    a_delta_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (delta0 == DELTA_NONE && delta1 == DELTA_NONE &&
                   delta2 == DELTA_NONE && delta3 == DELTA_NONE))
        else $error("slot change without result");

endmodule
